/* rtl/hbfd_pkg.sv */
// ----------------------------------------------------------------------------
// hbfd_pkg: shared types and codes for the heartbeat failure detector
// Word layouts for both channels, the table entry layout, operation,
// result, status and register codes, and register reset values.
// ----------------------------------------------------------------------------
package hbfd_pkg;

  // operation codes carried in the mode field
  localparam logic [2:0] MODE_ADD   = 3'd0;
  localparam logic [2:0] MODE_REM   = 3'd1;
  localparam logic [2:0] MODE_HBEAT = 3'd2;
  localparam logic [2:0] MODE_TICK  = 3'd3;
  localparam logic [2:0] MODE_RECOV = 3'd4;
  localparam logic [2:0] MODE_QUERY = 3'd5;
  localparam logic [2:0] MODE_LIST  = 3'd6;
  localparam logic [2:0] MODE_RSVD  = 3'd7;

  // result codes
  localparam logic [1:0] RES_OK      = 2'd0;
  localparam logic [1:0] RES_INVALID = 2'd1;
  localparam logic [1:0] RES_NOTFND  = 2'd2;
  localparam logic [1:0] RES_FULL    = 2'd3;

  // node status codes
  localparam logic [1:0] ST_ALIVE   = 2'd0;
  localparam logic [1:0] ST_SUSPECT = 2'd1;
  localparam logic [1:0] ST_DEAD    = 2'd2;
  localparam logic [1:0] ST_RECOV   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_LIMIT   = 2'd1;
  localparam logic [1:0] REG_OWN_ID  = 2'd2;

  localparam logic [63:0] TIMEOUT_RST = 64'd5000;
  localparam logic [7:0]  LIMIT_RST   = 8'd3;
  localparam logic [63:0] OWN_ID_RST  = 64'd0;

  // most results one list operation reports
  localparam logic [4:0] RESULT_LIMIT = 5'd16;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] node_id;
    logic [63:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [1:0]  node_status;
    logic [63:0] seen_ms;
    logic [7:0]  miss_count;
    logic [4:0]  alive_total;
    logic        dead_valid;
    logic [63:0] dead_node;
    logic        last;
  } out_word_t;

  // one table entry as stored in the RAM
  typedef struct packed {
    logic [63:0] id;
    logic [63:0] seen;
    logic [7:0]  misses;
    logic [1:0]  status;
  } entry_t;

endpackage

/* rtl/heartbeat_failure_detector.sv */
// ----------------------------------------------------------------------------
// heartbeat_failure_detector: heartbeat timeout failure detector
// Ordered node table in a RAM, walked one entry per cycle (unless a list
// result stalls) by a small sequencer for lookup, timeout checks, compaction
// and dead-node lists.
//
//  channel  handshake                    word / data
//  -------  ---------------------------  ------------------------------------
//  in       in_valid_i  / in_ready_o     in_data_i   (mode, node_id, now_ms)
//  out      out_valid_o / out_ready_i    out_data_o  (one or more per item)
//  cfg      cfg_we_i (no wait)           cfg_idx_i, cfg_wdata_i
//
//  An item walks N table entries: up to the table fill for lookups, the
//  whole fill for tick and list. A remove then moves each later entry down
//  one place. The single table read port sets this pace. in_ready_o is
//  high only while no item is in work. Reset empties the table at once
//  (fill count cleared); there is no clearing pass. A stalled output holds
//  the walk only where a list result must wait.
//
module heartbeat_failure_detector #(
  parameter int MAX_NODES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hbfd_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hbfd_pkg::out_word_t  out_data_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [63:0]          cfg_wdata_i
);

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int EW = $bits(hbfd_pkg::entry_t);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [2:0]          mode_q, mode_d;
  logic [63:0]         id_q, id_d;
  logic [63:0]         now_q, now_d;
  logic [63:0]         thr_q, thr_d;
  logic                thr_neg_q, thr_neg_d;
  logic [CW-1:0]       rd_ptr_q, rd_ptr_d;
  logic                rv_q, rv_d;
  logic [CW-1:0]       ridx_q, ridx_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       alive_q, alive_d;
  logic [4:0]          n_q, n_d;
  hbfd_pkg::out_word_t res_q, res_d;
  logic                out_valid_q, out_valid_d;
  hbfd_pkg::out_word_t out_q, out_d;
  logic [63:0]         timeout_q;
  logic [7:0]          limit_q;
  logic [63:0]         own_q;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  hbfd_pkg::entry_t    ram_wdata;
  logic                ram_re;
  logic [EW-1:0]       ram_rdata;
  hbfd_pkg::entry_t    rd_ent;

  logic                out_free;
  logic                out_load;
  hbfd_pkg::out_word_t out_next;
  logic                match;
  logic                walk_done;
  logic                list_emit;
  logic                stall;
  logic [7:0]          lim_eff;
  logic [7:0]          miss_inc;
  logic [1:0]          tick_status;
  logic                tick_hit;
  logic [64:0]         thr_full;

  // table storage
  hbfd_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_NODES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_ent    = hbfd_pkg::entry_t'(ram_rdata);
  assign match     = (rd_ent.id == id_q);
  assign walk_done = !rv_q && (rd_ptr_q >= cnt_q);
  assign out_free  = !out_valid_q || out_ready_i;

  // a list result that must leave now, and the stall when it cannot
  assign list_emit = (mode_q == hbfd_pkg::MODE_LIST) && rv_q &&
                     (rd_ent.status == hbfd_pkg::ST_DEAD) &&
                     (n_q != 5'd0) && (n_q < hbfd_pkg::RESULT_LIMIT);
  assign stall     = (state_q == S_WALK) && list_emit && !out_free;

  // tick threshold: elapsed > timeout  <=>  seen < now - timeout, now >= timeout
  assign thr_full = {1'b0, in_data_i.now_ms} - {1'b0, timeout_q};

  // timeout check for the entry in the read register
  assign lim_eff     = (limit_q == 8'd0) ? 8'd1 : limit_q;
  assign miss_inc    = (rd_ent.misses == 8'hFF) ? 8'hFF : rd_ent.misses + 8'd1;
  assign tick_status = (miss_inc >= lim_eff) ? hbfd_pkg::ST_DEAD : hbfd_pkg::ST_SUSPECT;
  assign tick_hit    = !thr_neg_q && (rd_ent.seen < thr_q) &&
                       (rd_ent.status != hbfd_pkg::ST_DEAD) &&
                       (rd_ent.status != hbfd_pkg::ST_RECOV) &&
                       (rd_ent.id != own_q);

  // sequencer
  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    id_d      = id_q;
    now_d     = now_q;
    thr_d     = thr_q;
    thr_neg_d = thr_neg_q;
    rd_ptr_d  = rd_ptr_q;
    rv_d      = rv_q;
    ridx_d    = ridx_q;
    cnt_d     = cnt_q;
    alive_d   = alive_q;
    n_d       = n_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    out_load  = 1'b0;
    out_next  = '0;

    // pipelined table read, one entry per cycle unless a list result stalls
    if ((state_q == S_WALK) || (state_q == S_SHIFT)) begin
      if (!stall) begin
        if (rd_ptr_q < cnt_q) begin
          ram_re   = 1'b1;
          rd_ptr_d = rd_ptr_q + CW'(1);
          rv_d     = 1'b1;
          ridx_d   = rd_ptr_q;
        end else begin
          rv_d = 1'b0;
        end
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d    = in_data_i.mode;
          id_d      = in_data_i.node_id;
          now_d     = in_data_i.now_ms;
          thr_d     = thr_full[63:0];
          thr_neg_d = thr_full[64];
          rd_ptr_d  = '0;
          rv_d      = 1'b0;
          n_d       = 5'd0;
          res_d     = '0;
          if (((in_data_i.mode == hbfd_pkg::MODE_REM) && (in_data_i.node_id == own_q)) ||
              (in_data_i.mode == hbfd_pkg::MODE_RSVD)) begin
            res_d.result_code = hbfd_pkg::RES_INVALID;
            state_d           = S_RESP;
          end else begin
            state_d = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (mode_q == hbfd_pkg::MODE_TICK) begin
          // timeout check and write-back
          if (rv_q && tick_hit) begin
            ram_we           = 1'b1;
            ram_waddr        = ridx_q[IW-1:0];
            ram_wdata        = rd_ent;
            ram_wdata.misses = miss_inc;
            ram_wdata.status = tick_status;
            if (rd_ent.status == hbfd_pkg::ST_ALIVE) begin
              alive_d = alive_q - CW'(1);
            end
          end
          if (walk_done) begin
            state_d = S_RESP;
          end
        end else if (mode_q == hbfd_pkg::MODE_LIST) begin
          // hold one dead id back so the final one can carry last
          if (rv_q && !stall && (rd_ent.status == hbfd_pkg::ST_DEAD)) begin
            if (n_q == 5'd0) begin
              res_d.dead_node = rd_ent.id;
              n_d             = n_q + 5'd1;
            end else if (n_q < hbfd_pkg::RESULT_LIMIT) begin
              out_load             = 1'b1;
              out_next             = '0;
              out_next.alive_total = 5'(alive_q);
              out_next.dead_valid  = 1'b1;
              out_next.dead_node   = res_q.dead_node;
              res_d.dead_node      = rd_ent.id;
              n_d                  = n_q + 5'd1;
            end
          end
          if (walk_done) begin
            res_d.dead_valid = (n_q != 5'd0);
            state_d          = S_RESP;
          end
        end else begin
          // lookup for the single-node operations
          if (rv_q && match) begin
            state_d = S_RESP;
            unique case (mode_q)
              hbfd_pkg::MODE_REM: begin
                if (rd_ent.status == hbfd_pkg::ST_ALIVE) begin
                  alive_d = alive_q - CW'(1);
                end
                rd_ptr_d = ridx_q + CW'(1);
                rv_d     = 1'b0;
                state_d  = S_SHIFT;
              end
              hbfd_pkg::MODE_HBEAT: begin
                ram_we    = 1'b1;
                ram_waddr = ridx_q[IW-1:0];
                ram_wdata = '{id: id_q, seen: now_q, misses: 8'd0,
                              status: hbfd_pkg::ST_ALIVE};
                if (rd_ent.status != hbfd_pkg::ST_ALIVE) begin
                  alive_d = alive_q + CW'(1);
                end
              end
              hbfd_pkg::MODE_RECOV: begin
                ram_we           = 1'b1;
                ram_waddr        = ridx_q[IW-1:0];
                ram_wdata        = rd_ent;
                ram_wdata.status = hbfd_pkg::ST_RECOV;
                if (rd_ent.status == hbfd_pkg::ST_ALIVE) begin
                  alive_d = alive_q - CW'(1);
                end
              end
              hbfd_pkg::MODE_QUERY: begin
                res_d.node_status = rd_ent.status;
                res_d.seen_ms     = rd_ent.seen;
                res_d.miss_count  = rd_ent.misses;
              end
              default: begin
                // add of a known id changes nothing
              end
            endcase
          end else if (walk_done) begin
            state_d = S_RESP;
            if (mode_q == hbfd_pkg::MODE_ADD) begin
              if (cnt_q == CW'(MAX_NODES)) begin
                res_d.result_code = hbfd_pkg::RES_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_q[IW-1:0];
                ram_wdata = '{id: id_q, seen: 64'd0, misses: 8'd0,
                              status: hbfd_pkg::ST_ALIVE};
                cnt_d     = cnt_q + CW'(1);
                alive_d   = alive_q + CW'(1);
              end
            end else begin
              res_d.result_code = hbfd_pkg::RES_NOTFND;
            end
          end
        end
      end

      S_SHIFT: begin
        // compaction: entry j moves to j-1
        if (rv_q) begin
          ram_we    = 1'b1;
          ram_waddr = IW'(ridx_q - CW'(1));
          ram_wdata = rd_ent;
        end
        if (walk_done) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_next             = res_q;
          out_next.alive_total = 5'(alive_q);
          out_next.last        = 1'b1;
          state_d              = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // output register
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = out_next;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rv_q        <= 1'b0;
      cnt_q       <= '0;
      alive_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rv_q        <= rv_d;
      cnt_q       <= cnt_d;
      alive_q     <= alive_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= hbfd_pkg::TIMEOUT_RST;
      limit_q   <= hbfd_pkg::LIMIT_RST;
      own_q     <= hbfd_pkg::OWN_ID_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hbfd_pkg::REG_TIMEOUT: timeout_q <= cfg_wdata_i;
        hbfd_pkg::REG_LIMIT:   limit_q   <= cfg_wdata_i[7:0];
        hbfd_pkg::REG_OWN_ID:  own_q     <= cfg_wdata_i;
        default: begin
          // no register at this index
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    id_q      <= id_d;
    now_q     <= now_d;
    thr_q     <= thr_d;
    thr_neg_q <= thr_neg_d;
    rd_ptr_q  <= rd_ptr_d;
    ridx_q    <= ridx_d;
    n_q       <= n_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_NODES))
    else $error("table fill beyond capacity");

  a_alive_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alive_q <= cnt_q)
    else $error("alive count exceeds table fill");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready high right after an accepted word");

  a_nonlast_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> mode_q == hbfd_pkg::MODE_LIST)
    else $error("non-final result outside list operation");
`endif

endmodule

/* rtl/hbfd_ram.sv */
// ----------------------------------------------------------------------------
// hbfd_ram: generic simple dual-port RAM
// One write port, one read port with registered read data that holds
// its value while the read enable is low.
// ----------------------------------------------------------------------------
module hbfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* verif/heartbeat_failure_detector_tb.sv */
// ----------------------------------------------------------------------------
// testbench: heartbeat failure detector
// Drives request words into the detector and keeps its own copy of the node
// table and registers. Each response word is compared field by field with
// the oldest predicted word. Directed checks come first, then random traffic
// in phases with different register settings and idle patterns.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          POOL_SIZE   = 20;
  localparam int          QUIET_MAX   = 4000;
  localparam int          DRAIN_WAIT  = 40;
  localparam int          HOLD_CYCLES = 300;
  localparam logic [63:0] ALL_ONES    = '1;

  // table mirror: predicts the response words of each accepted request
  class detector_mirror;
    localparam int NODES = 16;

    logic [63:0]             timeout_ms;
    logic [7:0]              miss_limit;
    logic [63:0]             own_id;
    hbfd_pkg::entry_t        nodes [NODES];
    int                      fill;
    hbfd_pkg::out_word_t     due_words [$];
    int                      errors;

    function new();
      timeout_ms = hbfd_pkg::TIMEOUT_RST;
      miss_limit = hbfd_pkg::LIMIT_RST;
      own_id     = hbfd_pkg::OWN_ID_RST;
      fill       = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        hbfd_pkg::REG_TIMEOUT: timeout_ms = val;
        hbfd_pkg::REG_LIMIT:   miss_limit = val[7:0];
        hbfd_pkg::REG_OWN_ID:  own_id = val;
        default: ;
      endcase
    endfunction

    function int find(logic [63:0] id);
      for (int i = 0; i < fill; i++) begin
        if (nodes[i].id == id) return i;
      end
      return -1;
    endfunction

    function logic [4:0] alive_count();
      int n;
      n = 0;
      for (int i = 0; i < fill; i++) begin
        if (nodes[i].status == hbfd_pkg::ST_ALIVE) n++;
      end
      return n[4:0];
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    // update the table for one request word and queue its response words
    function void apply_request(hbfd_pkg::in_word_t w);
      hbfd_pkg::out_word_t r;
      int                  k;
      int                  ndead;
      int                  sent;
      logic [63:0]         elapsed;
      logic [7:0]          lim;
      r      = '0;
      r.last = 1'b1;
      k      = find(w.node_id);
      case (w.mode)
        hbfd_pkg::MODE_ADD: begin
          // known id is a no-op
          if (k < 0) begin
            if (fill >= NODES) begin
              r.result_code = hbfd_pkg::RES_FULL;
            end else begin
              nodes[fill].id     = w.node_id;
              nodes[fill].seen   = '0;
              nodes[fill].misses = '0;
              nodes[fill].status = hbfd_pkg::ST_ALIVE;
              fill++;
            end
          end
        end
        hbfd_pkg::MODE_REM: begin
          // self check comes before the lookup
          if (w.node_id == own_id) begin
            r.result_code = hbfd_pkg::RES_INVALID;
          end else if (k < 0) begin
            r.result_code = hbfd_pkg::RES_NOTFND;
          end else begin
            for (int i = k; i + 1 < fill; i++) nodes[i] = nodes[i + 1];
            fill--;
          end
        end
        hbfd_pkg::MODE_HBEAT: begin
          if (k < 0) begin
            r.result_code = hbfd_pkg::RES_NOTFND;
          end else begin
            nodes[k].seen   = w.now_ms;
            nodes[k].misses = '0;
            nodes[k].status = hbfd_pkg::ST_ALIVE;
          end
        end
        hbfd_pkg::MODE_TICK: begin
          lim = (miss_limit == 8'd0) ? 8'd1 : miss_limit;
          for (int i = 0; i < fill; i++) begin
            if (nodes[i].status != hbfd_pkg::ST_DEAD &&
                nodes[i].status != hbfd_pkg::ST_RECOV &&
                nodes[i].id != own_id) begin
              // time running backwards counts as no elapsed time
              elapsed = (w.now_ms >= nodes[i].seen) ? w.now_ms - nodes[i].seen : '0;
              if (elapsed > timeout_ms) begin
                if (nodes[i].misses != 8'hFF) nodes[i].misses = nodes[i].misses + 8'd1;
                nodes[i].status = (nodes[i].misses >= lim) ? hbfd_pkg::ST_DEAD
                                                           : hbfd_pkg::ST_SUSPECT;
              end
            end
          end
        end
        hbfd_pkg::MODE_RECOV: begin
          if (k < 0) r.result_code = hbfd_pkg::RES_NOTFND;
          else nodes[k].status = hbfd_pkg::ST_RECOV;
        end
        hbfd_pkg::MODE_QUERY: begin
          if (k < 0) begin
            r.result_code = hbfd_pkg::RES_NOTFND;
          end else begin
            r.node_status = nodes[k].status;
            r.seen_ms     = nodes[k].seen;
            r.miss_count  = nodes[k].misses;
          end
        end
        hbfd_pkg::MODE_LIST: ;
        default: r.result_code = hbfd_pkg::RES_INVALID;
      endcase

      r.alive_total = alive_count();
      if (w.mode != hbfd_pkg::MODE_LIST) begin
        due_words.push_back(r);
      end else begin
        // one word per dead node in table order, at most RESULT_LIMIT, or a single empty word
        ndead = 0;
        for (int i = 0; i < fill; i++) begin
          if (nodes[i].status == hbfd_pkg::ST_DEAD) ndead++;
        end
        if (ndead > int'(hbfd_pkg::RESULT_LIMIT)) ndead = int'(hbfd_pkg::RESULT_LIMIT);
        if (ndead == 0) begin
          due_words.push_back(r);
        end else begin
          sent = 0;
          for (int i = 0; i < fill; i++) begin
            if (nodes[i].status == hbfd_pkg::ST_DEAD && sent < ndead) begin
              sent++;
              r.dead_valid = 1'b1;
              r.dead_node  = nodes[i].id;
              r.last       = (sent == ndead);
              due_words.push_back(r);
            end
          end
        end
      end
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_field(string name, logic [63:0] got_v, logic [63:0] want_v);
      if (got_v !== want_v) report($sformatf("%s got %0h, want %0h", name, got_v, want_v));
    endtask

    // compare one response word against the oldest prediction
    task match_response(hbfd_pkg::out_word_t got);
      hbfd_pkg::out_word_t want;
      if (due_words.size() == 0) begin
        report($sformatf("response word with nothing pending: %h", got));
      end else begin
        want = due_words.pop_front();
        check_field("result_code", 64'(got.result_code), 64'(want.result_code));
        check_field("node_status", 64'(got.node_status), 64'(want.node_status));
        check_field("seen_ms", got.seen_ms, want.seen_ms);
        check_field("miss_count", 64'(got.miss_count), 64'(want.miss_count));
        check_field("alive_total", 64'(got.alive_total), 64'(want.alive_total));
        check_field("dead_valid", 64'(got.dead_valid), 64'(want.dead_valid));
        check_field("dead_node", got.dead_node, want.dead_node);
        check_field("last", 64'(got.last), 64'(want.last));
      end
    endtask
  endclass

  // DUT signals; the driven ones are known from time zero
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  hbfd_pkg::in_word_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  hbfd_pkg::out_word_t out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [1:0]          cfg_idx_i   = '0;
  logic [63:0]         cfg_wdata_i = '0;

  detector_mirror sb;
  logic [63:0]    id_pool [POOL_SIZE];
  logic [63:0]    clock_ms;
  int             tx_idle_pct  = 0;
  int             rx_stall_pct = 0;
  int             hold_seq     = 0;
  int             quiet_cycles = 0;

  heartbeat_failure_detector DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // response side: random stalls, plus one long hold when requested
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // response check and no-progress watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.match_response(out_data_o);
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function hbfd_pkg::in_word_t make_word(logic [2:0] op, logic [63:0] id, logic [63:0] now);
    hbfd_pkg::in_word_t w;
    w.mode    = op;
    w.node_id = id;
    w.now_ms  = now;
    return w;
  endfunction

  // mostly a clock that moves forward, sometimes jumps or extremes
  function logic [63:0] next_now();
    int roll;
    roll = $urandom_range(99);
    if (roll < 4) return rand64();
    if (roll < 6) return '0;
    if (roll < 8) return ALL_ONES;
    clock_ms = clock_ms + 64'($urandom_range(1500));
    return clock_ms;
  endfunction

  // offer one request word; returns at the edge where it is taken
  task send_word(hbfd_pkg::in_word_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.apply_request(w);
  endtask

  // stop offering and let every pending response drain out
  task settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task set_pace(int tx, int rx);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
  endtask

  // random traffic over the id pool; adds outweigh removes so the table fills
  task run_random(int count);
    hbfd_pkg::in_word_t w;
    int                 roll;
    for (int n = 0; n < count; n++) begin
      roll      = $urandom_range(99);
      w.node_id = ($urandom_range(9) == 0) ? rand64() : id_pool[$urandom_range(POOL_SIZE - 1)];
      w.now_ms  = next_now();
      if (roll < 18) begin
        w.mode = hbfd_pkg::MODE_ADD;
      end else if (roll < 28) begin
        w.mode = hbfd_pkg::MODE_REM;
        if ($urandom_range(4) == 0) w.node_id = sb.own_id;
      end else if (roll < 46) begin
        w.mode = hbfd_pkg::MODE_HBEAT;
      end else if (roll < 64) begin
        w.mode = hbfd_pkg::MODE_TICK;
      end else if (roll < 70) begin
        w.mode = hbfd_pkg::MODE_RECOV;
      end else if (roll < 82) begin
        w.mode = hbfd_pkg::MODE_QUERY;
      end else if (roll < 97) begin
        w.mode = hbfd_pkg::MODE_LIST;
      end else begin
        w.mode = hbfd_pkg::MODE_RSVD;
      end
      send_word(w);
    end
  endtask

  initial begin
    logic [63:0] node_a;
    logic [63:0] node_b;
    sb       = new();
    clock_ms = '0;
    id_pool[0] = '0;
    id_pool[1] = ALL_ONES;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = rand64();
    node_a = id_pool[2];
    node_b = id_pool[1];

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset registers, own id zero
    set_pace(0, 0);
    send_word(make_word(hbfd_pkg::MODE_LIST, rand64(), rand64()));
    send_word(make_word(hbfd_pkg::MODE_QUERY, node_a, '0));
    send_word(make_word(hbfd_pkg::MODE_REM, '0, '0));
    send_word(make_word(hbfd_pkg::MODE_REM, node_a, '0));
    send_word(make_word(hbfd_pkg::MODE_HBEAT, node_a, 64'd100));
    send_word(make_word(hbfd_pkg::MODE_RECOV, node_a, '0));
    send_word(make_word(hbfd_pkg::MODE_ADD, node_a, '0));
    send_word(make_word(hbfd_pkg::MODE_ADD, node_a, '0));
    send_word(make_word(hbfd_pkg::MODE_ADD, '0, '0));
    send_word(make_word(hbfd_pkg::MODE_ADD, node_b, '0));
    send_word(make_word(hbfd_pkg::MODE_HBEAT, node_a, 64'd1000));
    // now earlier than last heartbeat: elapsed clamps to zero
    send_word(make_word(hbfd_pkg::MODE_TICK, rand64(), '0));
    send_word(make_word(hbfd_pkg::MODE_TICK, rand64(), 64'd7000));
    send_word(make_word(hbfd_pkg::MODE_TICK, rand64(), ALL_ONES));
    send_word(make_word(hbfd_pkg::MODE_TICK, rand64(), ALL_ONES));
    send_word(make_word(hbfd_pkg::MODE_QUERY, node_a, '0));
    send_word(make_word(hbfd_pkg::MODE_LIST, rand64(), '0));
    send_word(make_word(hbfd_pkg::MODE_RECOV, node_a, '0));
    send_word(make_word(hbfd_pkg::MODE_TICK, rand64(), ALL_ONES));
    send_word(make_word(hbfd_pkg::MODE_HBEAT, node_b, ALL_ONES));
    send_word(make_word(hbfd_pkg::MODE_RSVD, rand64(), rand64()));
    send_word(make_word(hbfd_pkg::MODE_REM, node_a, '0));
    send_word(make_word(hbfd_pkg::MODE_QUERY, node_b, '0));
    send_word(make_word(hbfd_pkg::MODE_REM, '0, '0));

    // moderate timeout, sender idling
    settle();
    write_reg(hbfd_pkg::REG_TIMEOUT, 64'd2000);
    write_reg(hbfd_pkg::REG_LIMIT, 64'd2);
    write_reg(hbfd_pkg::REG_OWN_ID, id_pool[3]);
    set_pace(53, 0);
    run_random(70);

    // empty the table, fill it past capacity, kill every node, list them all
    settle();
    write_reg(hbfd_pkg::REG_LIMIT, 64'd0);
    write_reg(hbfd_pkg::REG_OWN_ID, rand64());
    set_pace(0, 53);
    while (sb.fill > 0) send_word(make_word(hbfd_pkg::MODE_REM, sb.nodes[0].id, '0));
    for (int i = 0; i <= 16; i++) send_word(make_word(hbfd_pkg::MODE_ADD, id_pool[i], '0));
    send_word(make_word(hbfd_pkg::MODE_QUERY, id_pool[5], '0));
    send_word(make_word(hbfd_pkg::MODE_TICK, rand64(), ALL_ONES));
    // long response hold while requests keep coming
    send_word(make_word(hbfd_pkg::MODE_LIST, rand64(), '0));
    hold_seq++;
    for (int i = 0; i < 4; i++) send_word(make_word(hbfd_pkg::MODE_QUERY, id_pool[i], '0));
    send_word(make_word(hbfd_pkg::MODE_HBEAT, id_pool[3], clock_ms));
    send_word(make_word(hbfd_pkg::MODE_ADD, id_pool[19], '0));
    send_word(make_word(hbfd_pkg::MODE_LIST, rand64(), '0));

    // one-millisecond timeout, widest miss limit
    settle();
    write_reg(hbfd_pkg::REG_TIMEOUT, 64'd1);
    write_reg(hbfd_pkg::REG_LIMIT, 64'd255);
    write_reg(hbfd_pkg::REG_OWN_ID, '0);
    set_pace(20, 20);
    run_random(70);

    // longest timeout: ticks never miss; own id all ones
    settle();
    write_reg(hbfd_pkg::REG_TIMEOUT, ALL_ONES);
    write_reg(hbfd_pkg::REG_LIMIT, 64'd1);
    write_reg(hbfd_pkg::REG_OWN_ID, ALL_ONES);
    set_pace(0, 0);
    run_random(60);

    settle();
    write_reg(hbfd_pkg::REG_TIMEOUT, 64'd3000);
    write_reg(hbfd_pkg::REG_LIMIT, 64'd3);
    write_reg(hbfd_pkg::REG_OWN_ID, id_pool[2]);
    set_pace(53, 53);
    run_random(50);

    // drain, then a short tail for stray words
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/hbfd_pkg.sv
rtl/hbfd_ram.sv
rtl/heartbeat_failure_detector.sv
verif/heartbeat_failure_detector_tb.sv
